// File: hdl/tts_pkg.sv
// shared constants, types and helpers for the tridiagonal solver
// no dependencies
package tts_pkg;

    localparam int MAX_ROWS  = 32;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int ROW_IDX_W = 6;
    localparam int IDX_W     = $clog2(MAX_ROWS);
    localparam int CNT_W     = $clog2(MAX_ROWS + 1);
    localparam int NUM_W     = DATA_W + FRAC_BITS;
    localparam int MUL_CNT_W = $clog2(DATA_W);
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FWD_READ,
        ST_FWD_MSTART,
        ST_FWD_MUL,
        ST_FWD_DSTART,
        ST_FWD_DIV,
        ST_BS_READ,
        ST_BS_LOAD,
        ST_BS_MUL,
        ST_OUT_READ,
        ST_OUT_LOAD,
        ST_OUT_WAIT
    } state_t;

    // saturate a 33 bit sum to 32 bits
    function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        begin
            if (v[DATA_W] != v[DATA_W-1])
                r = v[DATA_W] ? Q_MIN : Q_MAX;
            else
                r = v[DATA_W-1:0];
            return r;
        end
    endfunction

endpackage

// File: hdl/tridiagonal_thomas_solver.sv
// tridiagonal system solver, Thomas algorithm in Q16.16, rows in, solution entries out
// depends on tts_pkg, tts_mul, tts_div
// forward row: a serial multiply and then a divide before the next input slot
// back substitution: one serial multiply per entry below the top one
// output: each solution entry is read, loaded and then held until the sink takes it
// reset clears control state and counters; coefficient stores hold no reset value
module tridiagonal_thomas_solver (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_stall,
    input  logic signed [tts_pkg::DATA_W-1:0]           lower_coef,
    input  logic signed [tts_pkg::DATA_W-1:0]           diag_coef,
    input  logic signed [tts_pkg::DATA_W-1:0]           upper_coef,
    input  logic signed [tts_pkg::DATA_W-1:0]           rhs_value,
    input  logic                                        last_row,
    output logic                                        out_valid,
    input  logic                                        out_stall,
    output logic signed [tts_pkg::DATA_W-1:0]           solution_value,
    output logic [tts_pkg::ROW_IDX_W-1:0]               row_index,
    output logic                                        last_of_run,
    output logic                                        singular_flag,
    output logic                                        overflow_flag
);
    import tts_pkg::*;

    state_t state_reg, state_next;

    logic signed [DATA_W-1:0] alpha_mem [MAX_ROWS];
    logic signed [DATA_W-1:0] beta_mem [MAX_ROWS];
    logic signed [DATA_W-1:0] alpha_rd_reg, beta_rd_reg;

    logic signed [DATA_W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic                     last_reg;
    logic signed [DATA_W-1:0] den_reg, num_reg, negc_reg;
    logic signed [DATA_W-1:0] x_reg, opb_reg, opa_reg;
    logic [CNT_W-1:0]         row_count_reg, n_reg;
    logic [IDX_W-1:0]         k_reg, idx_reg;
    logic                     singular_reg, overflow_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] sol_reg;
    logic [ROW_IDX_W-1:0]     row_index_reg;
    logic                     last_out_reg, sing_out_reg, ovf_out_reg;

    logic                     in_acc, out_acc, full;
    logic [IDX_W-1:0]         rd_addr, top_idx;
    logic                     mul_start, div_start;
    logic signed [DATA_W-1:0] m1_a, m1_b, m2_a, m2_b;
    logic                     m1_done, m2_done, da_done, db_done;
    logic signed [DATA_W-1:0] m1_p, m2_p, qa, qb;
    logic                     da_hit, db_hit;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid_reg && !out_stall;
    assign full    = (row_count_reg == CNT_W'(MAX_ROWS));
    assign top_idx = IDX_W'(n_reg - 1'b1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    if (!full)
                        state_next = ST_FWD_READ;
                    else if (last_row)
                        state_next = ST_BS_READ;
                end
            ST_FWD_READ:   state_next = ST_FWD_MSTART;
            ST_FWD_MSTART: state_next = ST_FWD_MUL;
            ST_FWD_MUL:    if (m1_done && m2_done) state_next = ST_FWD_DSTART;
            ST_FWD_DSTART: state_next = ST_FWD_DIV;
            ST_FWD_DIV:
                if (da_done && db_done)
                    state_next = last_reg ? ST_BS_READ : ST_IDLE;
            ST_BS_READ:    state_next = ST_BS_LOAD;
            ST_BS_LOAD:
                if (k_reg != top_idx)
                    state_next = ST_BS_MUL;
                else if (k_reg == '0)
                    state_next = ST_OUT_READ;
                else
                    state_next = ST_BS_READ;
            ST_BS_MUL:
                if (m1_done)
                    state_next = (k_reg == '0) ? ST_OUT_READ : ST_BS_READ;
            ST_OUT_READ:   state_next = ST_OUT_LOAD;
            ST_OUT_LOAD:   state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:
                if (!out_stall)
                    state_next = (idx_reg == top_idx) ? ST_IDLE : ST_OUT_READ;
            default:       state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        mul_start = 1'b0;
        div_start = 1'b0;
        rd_addr   = '0;
        m1_a      = a_reg;
        m1_b      = (row_count_reg == '0) ? '0 : alpha_rd_reg;
        m2_a      = a_reg;
        m2_b      = (row_count_reg == '0) ? '0 : beta_rd_reg;
        case (state_reg)
            ST_FWD_READ:   rd_addr = IDX_W'(row_count_reg - 1'b1);
            ST_FWD_MSTART: mul_start = 1'b1;
            ST_FWD_DSTART: div_start = 1'b1;
            ST_BS_READ:    rd_addr = k_reg;
            ST_BS_LOAD:
            begin
                m1_a      = alpha_rd_reg;
                m1_b      = x_reg;
                mul_start = (k_reg != top_idx);
            end
            ST_BS_MUL:
            begin
                m1_a = opa_reg;
                m1_b = x_reg;
            end
            ST_OUT_READ:   rd_addr = idx_reg;
            default:       rd_addr = '0;
        endcase
    end

    tts_mul u_mul_alpha (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (m1_a),
        .mplier (m1_b),
        .done   (m1_done),
        .prod   (m1_p)
    );

    tts_mul u_mul_beta (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (m2_a),
        .mplier (m2_b),
        .done   (m2_done),
        .prod   (m2_p)
    );

    tts_div u_div_alpha (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (negc_reg),
        .den   (den_reg),
        .done  (da_done),
        .quot  (qa),
        .hit   (da_hit)
    );

    tts_div u_div_beta (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (db_done),
        .quot  (qb),
        .hit   (db_hit)
    );

    // coefficient stores, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FWD_DIV && da_done && db_done)
        begin
            alpha_mem[IDX_W'(row_count_reg)] <= last_reg ? '0 : qa;
            beta_mem[IDX_W'(row_count_reg)]  <= qb;
        end
        else if (state_reg == ST_BS_MUL && m1_done)
            beta_mem[k_reg] <= sat_sum((DATA_W+1)'(m1_p) + (DATA_W+1)'(opb_reg));
        alpha_rd_reg <= alpha_mem[rd_addr];
        beta_rd_reg  <= beta_mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_count_reg <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            idx_reg       <= '0;
            singular_reg  <= 1'b0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                    if (in_acc && full)
                    begin
                        overflow_reg <= 1'b1;
                        n_reg        <= row_count_reg;
                        k_reg        <= IDX_W'(row_count_reg - 1'b1);
                    end
                ST_FWD_DIV:
                    if (da_done && db_done)
                    begin
                        if ((da_hit && !last_reg) || db_hit)
                            singular_reg <= 1'b1;
                        row_count_reg <= row_count_reg + 1'b1;
                        n_reg         <= row_count_reg + 1'b1;
                        k_reg         <= IDX_W'(row_count_reg);
                    end
                ST_BS_LOAD:
                    if (k_reg == top_idx && k_reg != '0)
                        k_reg <= k_reg - 1'b1;
                ST_BS_MUL:
                    if (m1_done)
                    begin
                        if (k_reg != '0)
                            k_reg <= k_reg - 1'b1;
                        idx_reg <= '0;
                    end
                ST_OUT_LOAD:
                    out_valid_reg <= 1'b1;
                ST_OUT_WAIT:
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        idx_reg       <= idx_reg + 1'b1;
                        if (idx_reg == top_idx)
                        begin
                            row_count_reg <= '0;
                            singular_reg  <= 1'b0;
                            overflow_reg  <= 1'b0;
                            idx_reg       <= '0;
                        end
                    end
                default:
                    idx_reg <= idx_reg;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_reg    <= lower_coef;
            b_reg    <= diag_coef;
            c_reg    <= upper_coef;
            d_reg    <= rhs_value;
            last_reg <= last_row;
        end
        if (state_reg == ST_FWD_MUL && m1_done)
        begin
            den_reg  <= sat_sum((DATA_W+1)'(b_reg) + (DATA_W+1)'(m1_p));
            num_reg  <= sat_sum((DATA_W+1)'(d_reg) - (DATA_W+1)'(m2_p));
            negc_reg <= sat_sum(-(DATA_W+1)'(c_reg));
        end
        if (state_reg == ST_BS_LOAD)
        begin
            opa_reg <= alpha_rd_reg;
            opb_reg <= beta_rd_reg;
            if (k_reg == top_idx)
                x_reg <= beta_rd_reg;
        end
        if (state_reg == ST_BS_MUL && m1_done)
            x_reg <= sat_sum((DATA_W+1)'(m1_p) + (DATA_W+1)'(opb_reg));
        if (state_reg == ST_OUT_LOAD)
        begin
            sol_reg       <= beta_rd_reg;
            row_index_reg <= ROW_IDX_W'(idx_reg);
            last_out_reg  <= (idx_reg == top_idx);
            sing_out_reg  <= singular_reg;
            ovf_out_reg   <= overflow_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign solution_value = sol_reg;
    assign row_index      = row_index_reg;
    assign last_of_run    = last_out_reg;
    assign singular_flag  = sing_out_reg;
    assign overflow_flag  = ovf_out_reg;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg <= CNT_W'(MAX_ROWS))
        else $error("row count beyond capacity");

    a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == ST_OUT_WAIT)
        else $error("result shown outside output wait");

    a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && last_out_reg) |=> (row_count_reg == '0 && !overflow_reg))
        else $error("run state not cleared after final entry");

    a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while busy");

endmodule

// File: hdl/tts_mul.sv
// bit-serial signed fixed point multiplier, one multiplier bit per cycle
// floor shift by the fraction width and saturation at the end
// depends on tts_pkg
module tts_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [tts_pkg::DATA_W-1:0]   mcand,
    input  logic signed [tts_pkg::DATA_W-1:0]   mplier,
    output logic                                done,
    output logic signed [tts_pkg::DATA_W-1:0]   prod
);
    import tts_pkg::*;

    logic signed [2*DATA_W-1:0] acc_reg, acc_next;
    logic signed [2*DATA_W-1:0] mc_reg, mc_next;
    logic [DATA_W-1:0]          mp_reg, mp_next;
    logic [MUL_CNT_W-1:0]       cnt_reg, cnt_next;
    logic                       run_reg, run_next;
    logic                       done_reg, done_next;
    logic signed [2*DATA_W-1:0] addend;
    logic signed [2*DATA_W-1:0] shifted;
    logic                       top_bit;

    // one partial product per cycle, sign bit has negative weight
    always_comb
    begin
        top_bit   = (cnt_reg == MUL_CNT_W'(DATA_W - 1));
        addend    = mp_reg[0] ? (top_bit ? -mc_reg : mc_reg) : '0;
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next = '0;
            mc_next  = (2*DATA_W)'(mcand);
            mp_next  = mplier;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next = acc_reg + addend;
            mc_next  = mc_reg <<< 1;
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (top_bit)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    // floor shift and saturate
    always_comb
    begin
        shifted = acc_reg >>> FRAC_BITS;
        if (shifted > (2*DATA_W)'(Q_MAX))
            prod = Q_MAX;
        else if (shifted < (2*DATA_W)'(Q_MIN))
            prod = Q_MIN;
        else
            prod = shifted[DATA_W-1:0];
    end

    assign done = done_reg;

endmodule

// File: hdl/tts_div.sv
// bit-serial restoring divider, (num << FRAC_BITS) / den rounded toward zero
// one quotient bit per cycle, saturation and zero pivot flagged
// depends on tts_pkg
module tts_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [tts_pkg::DATA_W-1:0]   num,
    input  logic signed [tts_pkg::DATA_W-1:0]   den,
    output logic                                done,
    output logic signed [tts_pkg::DATA_W-1:0]   quot,
    output logic                                hit
);
    import tts_pkg::*;

    logic [DATA_W-1:0]    dmag_reg, dmag_next;
    logic [NUM_W-1:0]     nsh_reg, nsh_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]     q_reg, q_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic                 zden_reg, zden_next;
    logic                 nneg_reg, nneg_next;
    logic                 qneg_reg, qneg_next;
    logic [DATA_W:0]      trial;
    logic                 fits;
    logic [DATA_W-1:0]    nmag;

    // one restoring step per cycle
    always_comb
    begin
        nmag      = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
        trial     = {rem_reg, nsh_reg[NUM_W-1]};
        fits      = (trial >= {1'b0, dmag_reg});
        dmag_next = dmag_reg;
        nsh_next  = nsh_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        zden_next = zden_reg;
        nneg_next = nneg_reg;
        qneg_next = qneg_reg;
        if (start)
        begin
            dmag_next = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
            nsh_next  = {nmag, {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = '0;
            nneg_next = num[DATA_W-1];
            qneg_next = num[DATA_W-1] ^ den[DATA_W-1];
            zden_next = (den == '0);
            run_next  = (den != '0);
            done_next = (den == '0);
        end
        else if (run_reg)
        begin
            rem_next = fits ? DATA_W'(trial - {1'b0, dmag_reg}) : trial[DATA_W-1:0];
            q_next   = {q_reg[NUM_W-2:0], fits};
            nsh_next = nsh_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(NUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dmag_reg <= dmag_next;
        nsh_reg  <= nsh_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        zden_reg <= zden_next;
        nneg_reg <= nneg_next;
        qneg_reg <= qneg_next;
    end

    // sign and saturation of the result
    always_comb
    begin
        hit  = 1'b0;
        quot = '0;
        if (zden_reg)
        begin
            hit  = 1'b1;
            quot = nneg_reg ? Q_MIN : Q_MAX;
        end
        else if (qneg_reg)
        begin
            if (q_reg > NUM_W'({1'b1, {(DATA_W-1){1'b0}}}))
            begin
                hit  = 1'b1;
                quot = Q_MIN;
            end
            else
                quot = DATA_W'(-q_reg);
        end
        else
        begin
            if (q_reg > NUM_W'(Q_MAX))
            begin
                hit  = 1'b1;
                quot = Q_MAX;
            end
            else
                quot = q_reg[DATA_W-1:0];
        end
    end

    assign done = done_reg;

endmodule
